### sv/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned LANES    = 8;
  localparam int unsigned LANE_W   = $clog2(LANES);
  localparam int unsigned ROWS     = DEPTH / LANES;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned CNT_W    = 4;

  // access_mode encodings
  localparam logic [1:0] MODE_RO = 2'd0;
  localparam logic [1:0] MODE_WO = 2'd1;
  localparam logic [1:0] MODE_RW = 2'd2;

  // command encodings
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_FORBIDDEN = 1'b1;

  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(LANES);

  typedef logic [PTR_W-1:0] ptr_t;

  // pointer plus a small increment, wrapped at the buffer end
  function automatic ptr_t wrap_add(input ptr_t ptr, input logic [CNT_W-1:0] inc);
    logic [PTR_W:0] sum;
    sum = {1'b0, ptr} + (PTR_W + 1)'(inc);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/brb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/byte_ring_buffer_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Ports                                      | Transaction when
// -----------+--------------------------------------------+----------------------------
// request    | start, command_i, byte_count_i, write_data_i | start high, busy low
// result     | result_valid_o, status_o, done_count_o,    | result_valid_o high
//            | read_data_o                                |
// config     | cfg_we_i, cfg_wdata_i (access_mode)        | cfg_we_i high
//
// One request per cycle; busy stays low. The result passes first through the
// registered read of the eight byte-wide bank RAMs, then through the result
// register. Pointers and the full flag update at the accepting edge.
// Reset clears pointers, flag and pipeline valids and sets access_mode to 2; the
// byte store itself is not cleared. The receiver cannot stall.

module byte_ring_buffer_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic [63:0] write_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  output logic             result_valid_o,
  output logic             status_o,
  output logic [3:0]       done_count_o,
  output logic [63:0]      read_data_o
);

  localparam int unsigned PW = brb_pkg::PTR_W;
  localparam int unsigned CW = brb_pkg::CNT_W;
  localparam int unsigned NL = brb_pkg::LANES;
  localparam int unsigned LW = brb_pkg::LANE_W;
  localparam int unsigned RW = brb_pkg::ROW_W;

  logic [1:0]    mode_q;
  brb_pkg::ptr_t rp_q, rp_d;
  brb_pkg::ptr_t wp_q, wp_d;
  logic          lww_q, lww_d;

  logic          accept;
  logic [CW-1:0] cnt_sat;
  logic          rd_ok, wr_ok, forbid;
  logic [PW:0]   used, free, lim;
  logic [CW-1:0] grant;

  logic          bank_we    [NL];
  logic [RW-1:0] bank_waddr [NL];
  logic [7:0]    bank_wdata [NL];
  logic [RW-1:0] bank_raddr [NL];
  logic [7:0]    bank_rdata [NL];

  logic          s1_valid_q, s1_status_q, s1_is_read_q;
  logic [CW-1:0] s1_cnt_q;
  logic [LW-1:0] s1_rot_q;

  logic          out_valid_q, out_status_q;
  logic [CW-1:0] out_cnt_q;
  logic [63:0]   out_data_q, out_data_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cnt_sat = (byte_count_i > brb_pkg::MAX_CNT) ? brb_pkg::MAX_CNT : byte_count_i;
    rd_ok   = (mode_q == brb_pkg::MODE_RO) || (mode_q == brb_pkg::MODE_RW);
    wr_ok   = (mode_q == brb_pkg::MODE_WO) || (mode_q == brb_pkg::MODE_RW);
    forbid  = (cnt_sat != '0) && ((command_i == brb_pkg::CMD_WRITE) ? !wr_ok : !rd_ok);

    if (wp_q == rp_q) begin
      used = lww_q ? brb_pkg::DEPTH_EXT : '0;
    end else if (wp_q > rp_q) begin
      used = {1'b0, wp_q} - {1'b0, rp_q};
    end else begin
      used = brb_pkg::DEPTH_EXT - {1'b0, rp_q} + {1'b0, wp_q};
    end
    free = brb_pkg::DEPTH_EXT - used;
    lim  = (command_i == brb_pkg::CMD_WRITE) ? free : used;

    if (forbid) begin
      grant = '0;
    end else if (lim < (PW + 1)'(cnt_sat)) begin
      grant = lim[CW-1:0];
    end else begin
      grant = cnt_sat;
    end
  end

  always_comb begin
    brb_pkg::ptr_t wa [NL];
    brb_pkg::ptr_t ra [NL];
    logic [LW-1:0] woff [NL];
    logic [LW-1:0] roff [NL];
    for (int b = 0; b < NL; b++) begin
      // lane b holds byte woff of this transaction
      woff[b]        = LW'(b) - wp_q[LW-1:0];
      roff[b]        = LW'(b) - rp_q[LW-1:0];
      wa[b]          = brb_pkg::wrap_add(wp_q, CW'(woff[b]));
      ra[b]          = brb_pkg::wrap_add(rp_q, CW'(roff[b]));
      bank_waddr[b]  = wa[b][PW-1:LW];
      bank_raddr[b]  = ra[b][PW-1:LW];
      bank_wdata[b]  = write_data_i[8*woff[b] +: 8];
      bank_we[b]     = accept && (command_i == brb_pkg::CMD_WRITE) &&
                       (CW'(woff[b]) < grant);
    end
  end

  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    lww_d = lww_q;
    if (accept && (grant != '0)) begin
      if (command_i == brb_pkg::CMD_WRITE) begin
        wp_d  = brb_pkg::wrap_add(wp_q, grant);
        lww_d = 1'b1;
      end else begin
        rp_d  = brb_pkg::wrap_add(rp_q, grant);
        lww_d = 1'b0;
      end
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_bank
    brb_ram #(
      .WIDTH (8),
      .DEPTH (brb_pkg::ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr[g]),
      .wdata_i (bank_wdata[g]),
      .raddr_i (bank_raddr[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  // rotate bank outputs back into transaction byte order
  always_comb begin
    logic [LW-1:0] lane;
    lane       = '0;
    out_data_d = '0;
    for (int j = 0; j < NL; j++) begin
      lane = s1_rot_q + LW'(j);
      if (s1_is_read_q && (CW'(j) < s1_cnt_q)) begin
        out_data_d[8*j +: 8] = bank_rdata[lane];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= brb_pkg::MODE_RW;
      rp_q        <= '0;
      wp_q        <= '0;
      lww_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      lww_q       <= lww_d;
      s1_valid_q  <= accept;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q  <= forbid ? brb_pkg::STATUS_FORBIDDEN : brb_pkg::STATUS_OK;
    s1_is_read_q <= (command_i == brb_pkg::CMD_READ);
    s1_cnt_q     <= grant;
    s1_rot_q     <= rp_q[LW-1:0];
    out_status_q <= s1_status_q;
    out_cnt_q    <= s1_cnt_q;
    out_data_q   <= out_data_d;
  end

  assign result_valid_o = out_valid_q;
  assign status_o       = out_status_q;
  assign done_count_o   = out_cnt_q;
  assign read_data_o    = out_data_q;

endmodule

`default_nettype wire

### sim/tb_byte_ring_buffer_fifo.sv
`timescale 1ns / 1ps

module tb_byte_ring_buffer_fifo;
  import brb_pkg::*;

  // mode 3 has no package name: neither reads nor writes allowed
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic        status;
    logic [3:0]  done_count;
    logic [63:0] read_data;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [3:0]  byte_count_i;
  logic [63:0] write_data_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        result_valid_o;
  logic        status_o;
  logic [3:0]  done_count_o;
  logic [63:0] read_data_o;

  byte_ring_buffer_fifo i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .byte_count_i  (byte_count_i),
    .write_data_i  (write_data_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .done_count_o  (done_count_o),
    .read_data_o   (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the ring buffer
  logic [7:0]  ring_mem [DEPTH];
  int unsigned ring_rd;
  int unsigned ring_wr;
  bit          ring_full_flag;
  logic [1:0]  ring_mode;

  grant_t      expected_grants [$];
  int          mismatches;
  int          burst_left;

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned ring_used();
    if (ring_wr == ring_rd) begin
      return ring_full_flag ? DEPTH : 0;
    end
    if (ring_wr > ring_rd) begin
      return ring_wr - ring_rd;
    end
    return DEPTH - ring_rd + ring_wr;
  endfunction

  // applies one request to the shadow buffer and returns its grant
  function automatic grant_t apply_request(input logic cmd, input logic [3:0] req_cnt,
                                           input logic [63:0] data);
    grant_t      g;
    int unsigned cnt;
    int unsigned room;
    int unsigned n;
    g = '0;
    g.status = STATUS_OK;
    cnt = (req_cnt > MAX_CNT) ? LANES : req_cnt;
    if (cnt == 0) begin
      return g;
    end
    if (cmd == CMD_WRITE) begin
      if (ring_mode != MODE_WO && ring_mode != MODE_RW) begin
        g.status = STATUS_FORBIDDEN;
        return g;
      end
      room = DEPTH - ring_used();
      n = (cnt < room) ? cnt : room;
      for (int i = 0; i < n; i++) begin
        ring_mem[(ring_wr + i) % DEPTH] = data[8*i +: 8];
      end
      ring_wr = (ring_wr + n) % DEPTH;
      if (n > 0) begin
        ring_full_flag = 1'b1;
      end
    end else begin
      if (ring_mode != MODE_RO && ring_mode != MODE_RW) begin
        g.status = STATUS_FORBIDDEN;
        return g;
      end
      room = ring_used();
      n = (cnt < room) ? cnt : room;
      for (int i = 0; i < n; i++) begin
        g.read_data[8*i +: 8] = ring_mem[(ring_rd + i) % DEPTH];
      end
      ring_rd = (ring_rd + n) % DEPTH;
      if (n > 0) begin
        ring_full_flag = 1'b0;
      end
    end
    g.done_count = n[3:0];
    return g;
  endfunction

  task automatic send_request(input logic cmd, input logic [3:0] cnt,
                              input logic [63:0] data);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      burst_left = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 5);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= cmd;
    byte_count_i <= cnt;
    write_data_i <= data;
    do @(posedge clk_i); while (busy);
    expected_grants.push_back(apply_request(cmd, cnt, data));
  endtask

  task automatic send_random(input int write_pct);
    logic cmd;
    cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_READ;
    send_request(cmd, 4'($urandom_range(0, 15)), rand_word());
  endtask

  // hold off new requests until every outstanding transaction has returned
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ring_mode = mode;
  endtask

  task automatic test_directed_cases();
    write_mode(MODE_RW);
    send_request(CMD_READ,  4'd8,  '0);           // read of empty buffer
    send_request(CMD_WRITE, 4'd0,  '1);           // zero-byte write
    send_request(CMD_WRITE, 4'd8,  '1);
    send_request(CMD_WRITE, 4'd15, rand_word());  // count saturates at 8
    send_request(CMD_WRITE, 4'd9,  '0);
    send_request(CMD_READ,  4'd0,  rand_word());
    send_request(CMD_READ,  4'd1,  rand_word());
    send_request(CMD_READ,  4'd15, '1);
    send_request(CMD_READ,  4'd8,  '0);
    send_request(CMD_READ,  4'd8,  '0);           // clamped to what is left
    send_request(CMD_WRITE, 4'd3,  rand_word());
    send_request(CMD_WRITE, 4'd8,  rand_word());

    write_mode(MODE_RO);
    send_request(CMD_WRITE, 4'd5,  rand_word());  // forbidden
    send_request(CMD_WRITE, 4'd0,  rand_word());  // zero count wins over mode
    send_request(CMD_READ,  4'd4,  '0);

    write_mode(MODE_WO);
    send_request(CMD_READ,  4'd3,  '0);
    send_request(CMD_READ,  4'd0,  '0);
    send_request(CMD_WRITE, 4'd8,  rand_word());

    write_mode(MODE_NONE);
    send_request(CMD_READ,  4'd8,  '0);
    send_request(CMD_WRITE, 4'd8,  '1);
    send_request(CMD_READ,  4'd0,  '0);

    write_mode(MODE_RW);
    send_request(CMD_READ,  4'd15, '0);
    send_request(CMD_READ,  4'd8,  '0);
  endtask

  // align the write pointer so one write ends exactly at the buffer end,
  // then fill until full and push against the full buffer
  task automatic test_fill_to_wrap();
    int unsigned head;
    head = (DEPTH - ring_wr) % LANES;
    if (head != 0) begin
      send_request(CMD_WRITE, 4'(head), rand_word());
    end
    while (ring_used() < DEPTH) begin
      send_request(CMD_WRITE, 4'd8, rand_word());
    end
    send_request(CMD_WRITE, 4'd8,  rand_word());
    send_request(CMD_WRITE, 4'd15, rand_word());
    wait_idle();
  endtask

  task automatic test_drain_with_refill();
    while (ring_used() > 0) begin
      send_random(10);
    end
    send_request(CMD_READ, 4'd8, '0);
    send_request(CMD_READ, 4'd1, '0);
  endtask

  task automatic test_mixed_modes();
    logic [1:0] mode_order [4];
    mode_order = '{MODE_WO, MODE_RW, MODE_RO, MODE_NONE};
    for (int seg = 0; seg < 5; seg++) begin
      write_mode(seg < 4 ? mode_order[seg] : 2'($urandom_range(0, 3)));
      repeat (80) send_random($urandom_range(20, 80));
    end
  endtask

  always @(posedge clk_i) begin
    grant_t exp_g;
    if (rst_ni && result_valid_o) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected transaction: status %0d done_count %0d read_data %h",
               status_o, done_count_o, read_data_o);
        mismatches++;
      end else begin
        exp_g = expected_grants.pop_front();
        if (status_o !== exp_g.status) begin
          $error("status: expected %0d, got %0d", exp_g.status, status_o);
          mismatches++;
        end
        if (done_count_o !== exp_g.done_count) begin
          $error("done_count: expected %0d, got %0d", exp_g.done_count, done_count_o);
          mismatches++;
        end
        if (read_data_o !== exp_g.read_data) begin
          $error("read_data: expected %h, got %h", exp_g.read_data, read_data_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    command_i      <= CMD_READ;
    byte_count_i   <= '0;
    write_data_i   <= '0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= MODE_RW;
    ring_rd        = 0;
    ring_wr        = 0;
    ring_full_flag = 1'b0;
    ring_mode      = MODE_RW;
    mismatches     = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_fill_to_wrap();
    test_drain_with_refill();
    test_mixed_modes();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
